[rtl/core/rbrt_pkg.sv]
// Shared types and constants for the receive buffer ring tracker.
// Used by the tracker unit and the slot engine in rtl/core; depends on nothing else.

package rbrt_pkg;

    // Number of host receive buffer slots in the ring.
    localparam int unsigned SLOTS    = 64;
    localparam int unsigned SLOT_W   = $clog2(SLOTS);

    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned PAGE_W   = 8;
    localparam int unsigned SLOT_OUT_W = 6;

    localparam logic [SIZE_W-1:0] HDR_BYTES   = 16'd4;
    localparam logic [PAGE_W-1:0] START_RESET = 8'h46;
    localparam logic [PAGE_W-1:0] STOP_RESET  = 8'hAA;

    // Configuration register indexes.
    localparam logic REG_START_PAGE = 1'b0;
    localparam logic REG_STOP_PAGE  = 1'b1;

    // Input command codes.
    localparam logic CMD_POST   = 1'b0;
    localparam logic CMD_PACKET = 1'b1;

    typedef enum logic [2:0] {
        ST_POSTED    = 3'd0,
        ST_FULL      = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_RECEIVED  = 3'd3,
        ST_TOO_LARGE = 3'd4
    } status_t;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] buffer_size;
        logic [SIZE_W-1:0] packet_count;
        logic [PAGE_W-1:0] next_page;
    } item_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [SIZE_W-1:0]     payload_length;
        logic                  is_packet;
    } result_t;

    typedef logic [SLOT_W-1:0] slot_ptr_t;

endpackage

[rtl/core/rx_buffer_ring_tracker_unit.sv]
// Receive buffer ring tracker: each input transaction passes the accept stage (with the
// slot memory read) and then the output register before its result reaches the master side.
// Throughput is one item per cycle while the master side takes results, set by the
// single read port of the slot size memory. Reset is asynchronous and active low: it
// empties the ring, loads start page 0x46, stop page 0xAA and next page 0x47; the
// slot memory is not cleared, so there is no clearing pass.

module rx_buffer_ring_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // buffer_size[15:0], packet_count[31:16], next_page[39:32]
    input  logic [0:0]  s_tuser,   // cmd[0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // slot_index[5:0], payload_length[21:6],
                                   // boundary_page[29:22], zero fill [31:30]
    output logic [2:0]  m_tuser,   // status[2:0]
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Device page ring configuration. The user must rewrite registers only while idle,
    // so no item sees a change half way through; the block does not enforce this.
    logic [rbrt_pkg::PAGE_W-1:0] start_page_reg, start_page_next;
    logic [rbrt_pkg::PAGE_W-1:0] stop_page_reg, stop_page_next;
    // Next packet page from the latest header; reset to one past the start page.
    logic [rbrt_pkg::PAGE_W-1:0] cur_next_page_reg, cur_next_page_next;

    rbrt_pkg::item_t   in_item;
    rbrt_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;
    logic              in_accept;

    logic                        out_valid_reg, out_valid_next;
    logic [rbrt_pkg::SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic [rbrt_pkg::SIZE_W-1:0] out_len_reg, out_len_next;
    logic [rbrt_pkg::PAGE_W-1:0] out_bound_reg, out_bound_next;
    rbrt_pkg::status_t           out_status_reg, out_status_next;

    logic [rbrt_pkg::PAGE_W-1:0] bound_raw;
    logic [rbrt_pkg::PAGE_W-1:0] bound_page;

    assign in_item.cmd          = s_tuser[0];
    assign in_item.buffer_size  = s_tdata[15:0];
    assign in_item.packet_count = s_tdata[31:16];
    assign in_item.next_page    = s_tdata[39:32];

    assign in_accept = s_tvalid && s_tready;

    rbrt_slot_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        start_page_next = start_page_reg;
        stop_page_next  = stop_page_reg;
        if (cfg_valid)
        begin
            case (cfg_index[0])
                rbrt_pkg::REG_START_PAGE: start_page_next = cfg_data;
                rbrt_pkg::REG_STOP_PAGE:  stop_page_next  = cfg_data;
                default:                  start_page_next = start_page_reg;
            endcase
        end
    end

    // Every packet transaction records its next page, whether or not a buffer
    // was waiting for it.
    always_comb
    begin
        cur_next_page_next = cur_next_page_reg;
        if (in_accept && (in_item.cmd == rbrt_pkg::CMD_PACKET))
        begin
            cur_next_page_next = in_item.next_page;
        end
    end

    // The boundary trails the next page by one; below the start of the device
    // ring it wraps to the last page before the stop page. The page register
    // already holds this item's value while the item sits in the check stage.
    assign bound_raw  = cur_next_page_reg - rbrt_pkg::PAGE_W'(1);
    assign bound_page = (bound_raw < start_page_reg) ?
                        (stop_page_reg - rbrt_pkg::PAGE_W'(1)) : bound_raw;

    // Output register: it takes a new result whenever it is empty or its
    // current result is being taken in the same cycle.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_len_next    = out_len_reg;
        out_bound_next  = out_bound_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res.status;
            out_slot_next   = res.slot_index;
            out_len_next    = res.payload_length;
            out_bound_next  = res.is_packet ? bound_page : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_page_reg    <= rbrt_pkg::START_RESET;
            stop_page_reg     <= rbrt_pkg::STOP_RESET;
            cur_next_page_reg <= rbrt_pkg::START_RESET + rbrt_pkg::PAGE_W'(1);
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            start_page_reg    <= start_page_next;
            stop_page_reg     <= stop_page_next;
            cur_next_page_reg <= cur_next_page_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_len_reg    <= out_len_next;
        out_bound_reg  <= out_bound_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_bound_reg, out_len_reg, out_slot_reg};

    // A post transaction can only report posted or ring full.
    a_post_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_packet |->
            (res.status == rbrt_pkg::ST_POSTED) || (res.status == rbrt_pkg::ST_FULL))
        else $error("post transaction produced a packet status");

    // A packet transaction never reports posted or ring full.
    a_packet_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_packet |->
            (res.status != rbrt_pkg::ST_POSTED) && (res.status != rbrt_pkg::ST_FULL))
        else $error("packet transaction produced a post status");

    // The payload length is only carried by a received packet.
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status != rbrt_pkg::ST_RECEIVED) |-> res.payload_length == '0)
        else $error("payload length set on a result that is not a reception");

    // A dropped packet reports slot zero.
    a_drop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == rbrt_pkg::ST_DROPPED) |-> res.slot_index == '0)
        else $error("dropped packet reports a slot");

endmodule

[rtl/core/rbrt_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no package dependencies.

module rbrt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rbrt_slot_engine.sv]
// Ring pointer logic, slot size memory and the size check stage.
// Depends on rbrt_pkg and rbrt_ram.

module rbrt_slot_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rbrt_pkg::item_t  in_item,
    output logic             res_valid,
    input  logic             res_ready,
    output rbrt_pkg::result_t res
);

    logic                        head_valid_reg, head_valid_next;
    rbrt_pkg::slot_ptr_t         head_slot_reg, head_slot_next;
    rbrt_pkg::slot_ptr_t         free_slot_reg, free_slot_next;

    logic                        s1_valid_reg, s1_valid_next;
    rbrt_pkg::status_t           s1_status_reg, s1_status_next;
    logic [rbrt_pkg::SLOT_OUT_W-1:0] s1_slot_reg, s1_slot_next;
    logic [rbrt_pkg::SIZE_W-1:0] s1_len_reg, s1_len_next;
    logic                        s1_check_reg, s1_check_next;
    logic                        s1_packet_reg, s1_packet_next;

    logic                        accept;
    logic                        ring_full;
    logic                        ram_we;
    logic                        ram_re;
    logic [rbrt_pkg::SIZE_W-1:0] ram_rdata;
    rbrt_pkg::slot_ptr_t         free_inc;
    rbrt_pkg::slot_ptr_t         head_inc;
    logic                        too_large;

    function automatic rbrt_pkg::slot_ptr_t slot_inc(input rbrt_pkg::slot_ptr_t p);
        if (p == rbrt_pkg::SLOT_W'(rbrt_pkg::SLOTS - 1))
        begin
            return '0;
        end
        return p + rbrt_pkg::SLOT_W'(1);
    endfunction

    // The stage holds one item; it may be refilled in the cycle it drains.
    assign in_ready  = !s1_valid_reg || res_ready;
    assign accept    = in_valid && in_ready;
    assign ring_full = head_valid_reg && (free_slot_reg == head_slot_reg);
    assign free_inc  = slot_inc(free_slot_reg);
    assign head_inc  = slot_inc(head_slot_reg);

    assign ram_we = accept && (in_item.cmd == rbrt_pkg::CMD_POST) && !ring_full;
    assign ram_re = accept && (in_item.cmd == rbrt_pkg::CMD_PACKET) && head_valid_reg;

    // Pointers are settled at accept time, so a write always lands before any
    // later read of the same slot.
    rbrt_ram #(
        .WIDTH (rbrt_pkg::SIZE_W),
        .DEPTH (rbrt_pkg::SLOTS)
    ) u_sizes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_slot_reg),
        .wdata (in_item.buffer_size),
        .re    (ram_re),
        .raddr (head_slot_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_slot_next  = head_slot_reg;
        free_slot_next  = free_slot_reg;
        s1_valid_next   = s1_valid_reg && !res_ready;
        s1_status_next  = s1_status_reg;
        s1_slot_next    = s1_slot_reg;
        s1_len_next     = s1_len_reg;
        s1_check_next   = s1_check_reg;
        s1_packet_next  = s1_packet_reg;
        if (accept)
        begin
            s1_valid_next  = 1'b1;
            s1_len_next    = in_item.packet_count - rbrt_pkg::HDR_BYTES;
            s1_check_next  = 1'b0;
            s1_packet_next = (in_item.cmd == rbrt_pkg::CMD_PACKET);
            if (in_item.cmd == rbrt_pkg::CMD_POST)
            begin
                s1_slot_next = rbrt_pkg::SLOT_OUT_W'(free_slot_reg);
                if (ring_full)
                begin
                    s1_status_next = rbrt_pkg::ST_FULL;
                end
                else
                begin
                    s1_status_next = rbrt_pkg::ST_POSTED;
                    free_slot_next = free_inc;
                    if (!head_valid_reg)
                    begin
                        head_slot_next  = free_slot_reg;
                        head_valid_next = 1'b1;
                    end
                end
            end
            else if (!head_valid_reg)
            begin
                s1_status_next = rbrt_pkg::ST_DROPPED;
                s1_slot_next   = '0;
            end
            else
            begin
                s1_status_next = rbrt_pkg::ST_RECEIVED;
                s1_slot_next   = rbrt_pkg::SLOT_OUT_W'(head_slot_reg);
                s1_check_next  = 1'b1;
                head_slot_next = head_inc;
                if (head_inc == free_slot_reg)
                begin
                    head_valid_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            head_slot_reg  <= '0;
            free_slot_reg  <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            head_slot_reg  <= head_slot_next;
            free_slot_reg  <= free_slot_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_status_reg <= s1_status_next;
        s1_slot_reg   <= s1_slot_next;
        s1_len_reg    <= s1_len_next;
        s1_check_reg  <= s1_check_next;
        s1_packet_reg <= s1_packet_next;
    end

    // Size check against the head slot read in the accept cycle.
    assign too_large = s1_len_reg > ram_rdata;

    always_comb
    begin
        res.status         = s1_status_reg;
        res.slot_index     = s1_slot_reg;
        res.payload_length = '0;
        res.is_packet      = s1_packet_reg;
        if (s1_check_reg)
        begin
            if (too_large)
            begin
                res.status = rbrt_pkg::ST_TOO_LARGE;
            end
            else
            begin
                res.payload_length = s1_len_reg;
            end
        end
    end

    assign res_valid = s1_valid_reg;

endmodule
